// ===== sv/jfpt_pkg.sv =====
// Package for the function profile table: payload structs, record and slot
// layouts, controller/datapath command and status groups, and shared constants.
// No dependencies.
package jfpt_pkg;

   localparam int PCT_W       = 7;    // percent fields
   localparam int PCT_SCALE   = 100;
   localparam int KEY_SHIFT   = 16;   // argument position sits above the type code
   localparam int SLOT_CNT_W  = 4;    // slot counts up to fifteen
   localparam int SUM_W       = 36;   // sum of up to fifteen 32-bit counts
   localparam int DIVIDEND_W  = 40;   // 32-bit count times the percent scale
   localparam int DIVISOR_W   = 36;
   localparam int TBIAS_W     = 11;   // up to fifteen percents added
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] REG_HOT_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STAB_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS_LIMIT = 2'd2;

   localparam logic [31:0]      HOT_LIMIT_RESET  = 32'd1000;
   localparam logic [PCT_W-1:0] STAB_LIMIT_RESET = 7'd80;
   localparam logic [PCT_W-1:0] BIAS_LIMIT_RESET = 7'd80;

   typedef enum logic [2:0] {
      CMD_ENTRY  = 3'd0,
      CMD_EXIT   = 3'd1,
      CMD_ARG    = 3'd2,
      CMD_BRANCH = 3'd3,
      CMD_QUERY  = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  func_index;
      logic [63:0] now_time;
      logic [63:0] start_time;
      logic [15:0] kind_code;
      logic [15:0] arg_position;
      logic [15:0] branch_number;
      logic        was_taken;
   } req_type;

   typedef struct packed {
      logic [63:0]      stamp_out;
      logic             record_present;
      logic             hot_flag;
      logic             stable_flag;
      logic             biased_flag;
      logic [31:0]      call_total;
      logic [63:0]      time_total;
      logic [PCT_W-1:0] stability_percent;
      logic [PCT_W-1:0] bias_percent;
      logic             slots_full;
   } rsp_type;

   typedef struct packed {
      logic [31:0]           call_count;
      logic [63:0]           time_sum;
      logic [SLOT_CNT_W-1:0] kind_used;
      logic [SLOT_CNT_W-1:0] branch_used;
      logic [PCT_W-1:0]      bias_pct;
      logic [PCT_W-1:0]      stab_pct;
      logic                  biased;
      logic                  stable;
      logic                  hot;
   } rec_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] freq;
   } kslot_type;

   typedef struct packed {
      logic [15:0] key;
      logic [31:0] taken;
      logic [31:0] not_taken;
   } bslot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REC,
      ST_K_RD,
      ST_K_CHK,
      ST_K_END,
      ST_B_RD,
      ST_B_CHK,
      ST_B_DIV,
      ST_B_END,
      ST_STAB,
      ST_STAB_DIV,
      ST_BIAS,
      ST_BIAS_DIV,
      ST_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic load_rec;
      logic clear_valid;
      logic slot_clear;
      logic k_read;
      logic k_check;
      logic k_end;
      logic b_read;
      logic b_check;
      logic b_acc;
      logic b_end;
      logic stab_start;
      logic stab_take;
      logic bias_start;
      logic bias_take;
      logic rec_write;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       present;
      logic       inrange;
      logic       slot_lt_kn;
      logic       slot_lt_bn;
      logic       tot_nonzero;
      logic       stab_go;
      logic       bias_go;
      logic       div_done;
      logic       rsp_free;
   } dp_stat_type;

endpackage

// ===== sv/jfpt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module jfpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/jfpt_div.sv =====
// Restoring divider for percent results, one quotient bit per cycle.
// The quotient is known to stay below 128. Depends on jfpt_pkg.
module jfpt_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [jfpt_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [jfpt_pkg::DIVISOR_W-1:0]  divisor,
   output logic                            done,
   output logic [jfpt_pkg::PCT_W-1:0]      quotient
);
   import jfpt_pkg::*;

   localparam int TRIAL_W = DIVISOR_W + PCT_W;
   localparam logic [2:0] LAST_STEP = 3'(PCT_W - 1);

   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [PCT_W-1:0]      q_ff, q_in;
   logic [2:0]            step_ff;
   logic                  busy_ff, done_ff;
   logic [TRIAL_W-1:0]    shifted;
   logic                  fits;

   always_comb begin
      shifted = TRIAL_W'(dsr_ff) << step_ff;
      fits    = TRIAL_W'(rem_ff) >= shifted;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (fits) begin
         rem_in        = DIVIDEND_W'(TRIAL_W'(rem_ff) - shifted);
         q_in[step_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == 3'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend;
         dsr_ff  <= divisor;
         q_ff    <= '0;
         step_ff <= LAST_STEP;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         step_ff <= step_ff - 3'd1;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== sv/jfpt_datapath.sv =====
// Datapath of the profile table: record, type-slot and branch-slot memories,
// scan accumulators, limit registers, divider and result register.
// Depends on jfpt_pkg, jfpt_ram and jfpt_div.
module jfpt_datapath #(
   parameter int FUNC_COUNT   = 256,
   parameter int KIND_SLOTS   = 8,
   parameter int BRANCH_SLOTS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  jfpt_pkg::req_type              req_data,
   input  jfpt_pkg::ctl_cmd_type          ctl,
   output jfpt_pkg::dp_stat_type          stat,
   input  logic                           csr_valid,
   input  logic [jfpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [jfpt_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output jfpt_pkg::rsp_type              rsp_data
);
   import jfpt_pkg::*;

   localparam int FIDX_W  = $clog2(FUNC_COUNT);
   localparam int KADDR_W = $clog2(FUNC_COUNT * KIND_SLOTS);
   localparam int BADDR_W = $clog2(FUNC_COUNT * BRANCH_SLOTS);

   function automatic logic [DIVIDEND_W-1:0] times_pct(input logic [31:0] x);
      times_pct = (DIVIDEND_W'(x) << 6) + (DIVIDEND_W'(x) << 5) + (DIVIDEND_W'(x) << 2);
   endfunction

   req_type               req_ff;
   rec_type               rec_ff, rec_rd, rec_in, rec_wr;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic [FUNC_COUNT-1:0] valid_ff;
   logic                  present_ff, full_ff;
   logic [SLOT_CNT_W-1:0] slot_ff;
   logic [31:0]           key_ff;
   logic                  kfound_ff;
   logic [SLOT_CNT_W-1:0] kidx_ff;
   logic [31:0]           kval_ff, kmax_ff;
   logic [SUM_W-1:0]      ksum_ff;
   logic                  bfound_ff;
   logic [SLOT_CNT_W-1:0] bidx_ff, bcnt_ff;
   logic [31:0]           bt_ff, bnt_ff;
   logic [TBIAS_W-1:0]    tbias_ff;
   logic [31:0]           hot_lim_ff;
   logic [PCT_W-1:0]      stab_lim_ff, bias_lim_ff;

   logic [FIDX_W-1:0]     fidx;
   logic                  inrange, present_now, count_kind;
   logic                  k_room, b_room, k_wr_en, b_wr_en;
   kslot_type             k_rd, k_wr;
   bslot_type             b_rd, b_wr;
   logic                  k_match, b_match;
   logic [31:0]           k_v, b_t, b_nt, b_maj;
   logic [32:0]           b_tot;
   logic [SLOT_CNT_W-1:0] k_wr_slot, b_wr_slot;
   logic [KADDR_W-1:0]    k_rd_addr, k_wr_addr;
   logic [BADDR_W-1:0]    b_rd_addr, b_wr_addr;
   logic                  div_start, div_done;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [PCT_W-1:0]      div_q;

   assign fidx        = FIDX_W'(req_ff.func_index);
   assign inrange     = 32'(req_ff.func_index) < 32'(FUNC_COUNT);
   assign present_now = inrange && valid_ff[fidx];
   assign count_kind  = req_ff.cmd != CMD_BRANCH;
   assign k_room      = 32'(rec_ff.kind_used) < 32'(KIND_SLOTS);
   assign b_room      = 32'(rec_ff.branch_used) < 32'(BRANCH_SLOTS);

   // type slot check: bump the first matching key, keep sum and max
   always_comb begin
      k_match = count_kind && !kfound_ff && k_rd.key == key_ff;
      k_v     = k_match ? k_rd.freq + 32'd1 : k_rd.freq;
   end

   // branch slot check
   always_comb begin
      b_match = !bfound_ff && b_rd.key == req_ff.branch_number;
      b_t     = (b_match && req_ff.was_taken) ? b_rd.taken + 32'd1 : b_rd.taken;
      b_nt    = (b_match && !req_ff.was_taken) ? b_rd.not_taken + 32'd1 : b_rd.not_taken;
      b_tot   = {1'b0, b_t} + {1'b0, b_nt};
      b_maj   = (b_t > b_nt) ? b_t : b_nt;
   end

   assign k_wr_slot = kfound_ff ? kidx_ff : rec_ff.kind_used;
   assign b_wr_slot = bfound_ff ? bidx_ff : rec_ff.branch_used;
   assign k_rd_addr = KADDR_W'(32'(fidx) * 32'(KIND_SLOTS) + 32'(slot_ff));
   assign k_wr_addr = KADDR_W'(32'(fidx) * 32'(KIND_SLOTS) + 32'(k_wr_slot));
   assign b_rd_addr = BADDR_W'(32'(fidx) * 32'(BRANCH_SLOTS) + 32'(slot_ff));
   assign b_wr_addr = BADDR_W'(32'(fidx) * 32'(BRANCH_SLOTS) + 32'(b_wr_slot));
   assign k_wr_en   = ctl.k_end && count_kind && (kfound_ff || k_room);
   assign b_wr_en   = ctl.b_end && (bfound_ff || b_room);

   always_comb begin
      k_wr.key  = key_ff;
      k_wr.freq = kfound_ff ? kval_ff : 32'd1;
      b_wr.key  = req_ff.branch_number;
      if (bfound_ff) begin
         b_wr.taken     = bt_ff;
         b_wr.not_taken = bnt_ff;
      end else begin
         b_wr.taken     = {31'd0, req_ff.was_taken};
         b_wr.not_taken = {31'd0, !req_ff.was_taken};
      end
   end

   // record as loaded at the start of an item
   always_comb begin
      rec_in = rec_rd;
      if (req_ff.cmd == CMD_ENTRY) begin
         if (present_now) begin
            rec_in.call_count = rec_rd.call_count + 32'd1;
         end else begin
            rec_in            = '0;
            rec_in.call_count = 32'd1;
         end
      end else if (req_ff.cmd == CMD_EXIT) begin
         rec_in.time_sum = rec_rd.time_sum + (req_ff.now_time - req_ff.start_time);
      end
   end

   // status refresh on exit and branch; hot follows the call count, the other flags follow the kept percents
   always_comb begin
      rec_wr = rec_ff;
      if (req_ff.cmd == CMD_EXIT || req_ff.cmd == CMD_BRANCH) begin
         rec_wr.hot = rec_ff.call_count >= hot_lim_ff;
         if (rec_ff.kind_used != '0) begin
            rec_wr.stable = rec_ff.stab_pct >= stab_lim_ff;
         end
         if (rec_ff.branch_used != '0) begin
            rec_wr.biased = rec_ff.bias_pct >= bias_lim_ff;
         end
      end
   end

   always_comb begin
      div_start = (ctl.b_check && b_tot != '0) || ctl.stab_start || ctl.bias_start;
      if (ctl.stab_start) begin
         div_dividend = times_pct(kmax_ff);
         div_divisor  = ksum_ff;
      end else if (ctl.bias_start) begin
         div_dividend = DIVIDEND_W'(tbias_ff);
         div_divisor  = DIVISOR_W'(bcnt_ff);
      end else begin
         div_dividend = times_pct(b_maj);
         div_divisor  = DIVISOR_W'(b_tot);
      end
   end

   always_comb begin
      rsp_in           = '0;
      rsp_in.stamp_out = (req_ff.cmd == CMD_ENTRY) ? req_ff.now_time : 64'd0;
      if (present_ff) begin
         rsp_in.record_present    = 1'b1;
         rsp_in.hot_flag          = rec_ff.hot;
         rsp_in.stable_flag       = rec_ff.stable;
         rsp_in.biased_flag       = rec_ff.biased;
         rsp_in.call_total        = rec_ff.call_count;
         rsp_in.time_total        = rec_ff.time_sum;
         rsp_in.stability_percent = rec_ff.stab_pct;
         rsp_in.bias_percent      = rec_ff.bias_pct;
      end
      rsp_in.slots_full = full_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hot_lim_ff   <= HOT_LIMIT_RESET;
         stab_lim_ff  <= STAB_LIMIT_RESET;
         bias_lim_ff  <= BIAS_LIMIT_RESET;
      end else begin
         if (ctl.clear_valid) begin
            valid_ff <= '0;
         end else if (ctl.rec_write) begin
            valid_ff[fidx] <= 1'b1;
         end
         if (ctl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               REG_HOT_LIMIT:  hot_lim_ff  <= csr_data;
               REG_STAB_LIMIT: stab_lim_ff <= csr_data[PCT_W-1:0];
               REG_BIAS_LIMIT: bias_lim_ff <= csr_data[PCT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         req_ff <= req_data;
      end
      if (ctl.rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (ctl.slot_clear) begin
         slot_ff <= '0;
      end else if (ctl.k_check || ctl.b_check) begin
         slot_ff <= slot_ff + SLOT_CNT_W'(1);
      end
      if (ctl.load_rec) begin
         rec_ff     <= rec_in;
         present_ff <= (req_ff.cmd != CMD_CLEAR) &&
                       (present_now || (req_ff.cmd == CMD_ENTRY && inrange));
         key_ff     <= (req_ff.cmd == CMD_EXIT) ? {16'd0, req_ff.kind_code}
                       : {req_ff.arg_position, req_ff.kind_code};
         full_ff    <= 1'b0;
         kfound_ff  <= 1'b0;
         ksum_ff    <= '0;
         kmax_ff    <= '0;
         bfound_ff  <= 1'b0;
         tbias_ff   <= '0;
         bcnt_ff    <= '0;
      end else if (ctl.k_check) begin
         ksum_ff <= ksum_ff + SUM_W'(k_v);
         if (k_v > kmax_ff) begin
            kmax_ff <= k_v;
         end
         if (k_match) begin
            kfound_ff <= 1'b1;
            kidx_ff   <= slot_ff;
            kval_ff   <= k_v;
         end
      end else if (ctl.k_end) begin
         if (count_kind && !kfound_ff) begin
            if (k_room) begin
               rec_ff.kind_used <= rec_ff.kind_used + SLOT_CNT_W'(1);
               ksum_ff          <= ksum_ff + SUM_W'(1);
               if (kmax_ff == '0) begin
                  kmax_ff <= 32'd1;
               end
            end else begin
               full_ff <= 1'b1;
            end
         end
      end else if (ctl.b_check) begin
         if (b_match) begin
            bfound_ff <= 1'b1;
            bidx_ff   <= slot_ff;
            bt_ff     <= b_t;
            bnt_ff    <= b_nt;
         end
      end else if (ctl.b_acc) begin
         tbias_ff <= tbias_ff + TBIAS_W'(div_q);
         bcnt_ff  <= bcnt_ff + SLOT_CNT_W'(1);
      end else if (ctl.b_end) begin
         if (!bfound_ff) begin
            if (b_room) begin
               // a fresh branch has one outcome: full majority
               rec_ff.branch_used <= rec_ff.branch_used + SLOT_CNT_W'(1);
               tbias_ff           <= tbias_ff + TBIAS_W'(PCT_SCALE);
               bcnt_ff            <= bcnt_ff + SLOT_CNT_W'(1);
            end else begin
               full_ff <= 1'b1;
            end
         end
      end else if (ctl.stab_take) begin
         rec_ff.stab_pct <= div_q;
      end else if (ctl.bias_take) begin
         rec_ff.bias_pct <= div_q;
      end else if (ctl.rec_write) begin
         rec_ff <= rec_wr;
      end
   end

   jfpt_ram #(.WIDTH($bits(rec_type)), .DEPTH(FUNC_COUNT)) u_rec_ram (
      .clock   (clock),
      .wr_en   (ctl.rec_write),
      .wr_addr (fidx),
      .wr_data (rec_wr),
      .rd_en   (ctl.load_req),
      .rd_addr (FIDX_W'(req_data.func_index)),
      .rd_data (rec_rd)
   );

   jfpt_ram #(.WIDTH($bits(kslot_type)), .DEPTH(FUNC_COUNT * KIND_SLOTS)) u_kind_ram (
      .clock   (clock),
      .wr_en   (k_wr_en),
      .wr_addr (k_wr_addr),
      .wr_data (k_wr),
      .rd_en   (ctl.k_read),
      .rd_addr (k_rd_addr),
      .rd_data (k_rd)
   );

   jfpt_ram #(.WIDTH($bits(bslot_type)), .DEPTH(FUNC_COUNT * BRANCH_SLOTS)) u_branch_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr),
      .rd_en   (ctl.b_read),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd)
   );

   jfpt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      stat.cmd         = req_ff.cmd;
      stat.present     = present_now;
      stat.inrange     = inrange;
      stat.slot_lt_kn  = slot_ff < rec_ff.kind_used;
      stat.slot_lt_bn  = slot_ff < rec_ff.branch_used;
      stat.tot_nonzero = b_tot != '0;
      stat.stab_go     = rec_ff.kind_used != '0 && ksum_ff != '0;
      stat.bias_go     = rec_ff.branch_used != '0 && bcnt_ff != '0;
      stat.div_done    = div_done;
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/jfpt_ctrl.sv =====
// Sequencer of the profile table: steps one item through record load, slot
// scans, divisions, record write-back and result load. Depends on jfpt_pkg.
module jfpt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jfpt_pkg::dp_stat_type stat,
   output jfpt_pkg::ctl_cmd_type ctl
);
   import jfpt_pkg::*;

   state_type state_ff, state_in;
   logic      is_branch;

   assign is_branch = stat.cmd == CMD_BRANCH;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_REC;
         end
         ST_REC: begin
            case (stat.cmd)
               CMD_ENTRY:  state_in = stat.inrange ? ST_WR : ST_RESP;
               CMD_EXIT, CMD_ARG, CMD_BRANCH:
                  state_in = stat.present ? ST_K_RD : ST_RESP;
               default:    state_in = ST_RESP;
            endcase
         end
         ST_K_RD:  state_in = stat.slot_lt_kn ? ST_K_CHK : ST_K_END;
         ST_K_CHK: state_in = ST_K_RD;
         ST_K_END: begin
            case (stat.cmd)
               CMD_ARG:    state_in = ST_WR;
               CMD_BRANCH: state_in = ST_B_RD;
               default:    state_in = ST_STAB;
            endcase
         end
         ST_B_RD:  state_in = stat.slot_lt_bn ? ST_B_CHK : ST_B_END;
         ST_B_CHK: state_in = stat.tot_nonzero ? ST_B_DIV : ST_B_RD;
         ST_B_DIV: begin
            if (stat.div_done) state_in = ST_B_RD;
         end
         ST_B_END: state_in = ST_STAB;
         ST_STAB: begin
            if (stat.stab_go) state_in = ST_STAB_DIV;
            else              state_in = is_branch ? ST_BIAS : ST_WR;
         end
         ST_STAB_DIV: begin
            if (stat.div_done) state_in = is_branch ? ST_BIAS : ST_WR;
         end
         ST_BIAS:     state_in = stat.bias_go ? ST_BIAS_DIV : ST_WR;
         ST_BIAS_DIV: begin
            if (stat.div_done) state_in = ST_WR;
         end
         ST_WR:   state_in = ST_RESP;
         ST_RESP: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            ctl.load_req = req_valid;
         end
         ST_REC: begin
            ctl.load_rec    = 1'b1;
            ctl.slot_clear  = 1'b1;
            ctl.clear_valid = stat.cmd == CMD_CLEAR;
         end
         ST_K_RD:  ctl.k_read = stat.slot_lt_kn;
         ST_K_CHK: ctl.k_check = 1'b1;
         ST_K_END: begin
            ctl.k_end      = 1'b1;
            ctl.slot_clear = 1'b1;
         end
         ST_B_RD:     ctl.b_read = stat.slot_lt_bn;
         ST_B_CHK:    ctl.b_check = 1'b1;
         ST_B_DIV:    ctl.b_acc = stat.div_done;
         ST_B_END:    ctl.b_end = 1'b1;
         ST_STAB:     ctl.stab_start = stat.stab_go;
         ST_STAB_DIV: ctl.stab_take = stat.div_done;
         ST_BIAS:     ctl.bias_start = stat.bias_go;
         ST_BIAS_DIV: ctl.bias_take = stat.div_done;
         ST_WR:       ctl.rec_write = 1'b1;
         ST_RESP:     ctl.rsp_load = stat.rsp_free;
         default: ;
      endcase
   end

endmodule

// ===== sv/jit_function_profile_table_core.sv =====
// Per-function profile table, direct-indexed by function number. Each item is
// one command (entry, exit, argument type, branch, query, clear) and yields
// one result. Items run one at a time through a sequencer; a new item is taken
// while the previous result still waits in the output register. Query, clear,
// unused commands, entry and commands on functions without a record skip the
// slot scans. Argument and exit time grows with the function's used type slots,
// and exit adds a stability division when the type counts sum to nonzero. Branch
// time grows with the used type and branch slots and with the scanned branch
// slots with counts, each of which needs a division, plus a stability division
// when the type counts sum to nonzero; the one-read-per-cycle slot memories and
// the shared percent divider set this time. A stalled result adds its stall.
// Configuration writes are taken in any cycle. Depends on jfpt_pkg, jfpt_ctrl
// and jfpt_datapath.
module jit_function_profile_table_core #(
   parameter int FUNC_COUNT   = 256,
   parameter int KIND_SLOTS   = 8,
   parameter int BRANCH_SLOTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  jfpt_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output jfpt_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [jfpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jfpt_pkg::CSR_DATA_W-1:0] csr_data
);
   import jfpt_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   assign csr_ready = 1'b1;

   jfpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .ctl       (ctl_cmd)
   );

   jfpt_datapath #(
      .FUNC_COUNT   (FUNC_COUNT),
      .KIND_SLOTS   (KIND_SLOTS),
      .BRANCH_SLOTS (BRANCH_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl_cmd),
      .stat      (dp_stat),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // one item in flight: after an accept the sequencer is busy
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while sequencer busy");

   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.rsp_load |-> dp_stat.rsp_free)
      else $error("result loaded over an unread result");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.stability_percent <= 7'd100 &&
                     rsp_data.bias_percent <= 7'd100))
      else $error("percent out of range");

endmodule
